// ===== design/vwna_pkg.sv =====
`timescale 1ns / 1ps

package vwna_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int FLOOR_W     = 11;
	localparam int CMP_W       = (CNT_W > FLOOR_W) ? CNT_W : FLOOR_W;
	localparam int VIDX_W      = 10;
	localparam int POS_W       = 32;
	localparam int NORM_W      = 16;
	localparam int SUM_W       = 32;
	localparam int ENTRY_W     = 3 * 32;

	localparam logic CMD_WELD    = 1'b0;
	localparam logic CMD_FACETED = 1'b1;

	typedef struct packed {
		logic accept;
		logic scan;
		logic take_match;
		logic append;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_need;
		logic match;
		logic scan_busy;
		logic out_busy;
	} ctl_sts_t;

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0]  s,
		input logic signed [NORM_W-1:0] d
	);
		logic [SUM_W:0] r;
		r = {s[SUM_W-1], s} + {{(SUM_W + 1 - NORM_W){d[NORM_W-1]}}, d};
		if (r[SUM_W] != r[SUM_W-1]) begin
			sat_add = r[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
		end else begin
			sat_add = r[SUM_W-1:0];
		end
	endfunction

endpackage

// ===== design/vwna_ram.sv =====
`timescale 1ns / 1ps

module vwna_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/vwna_ctrl.sv =====
`timescale 1ns / 1ps

module vwna_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  vwna_pkg::ctl_sts_t sts,
	output vwna_pkg::ctl_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_APPEND = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = sts.scan_need ? ST_SCAN : ST_APPEND;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.match) begin
					cmd.take_match = 1'b1;
					state_d        = ST_DONE;
				end else if (!sts.scan_busy) begin
					state_d = ST_APPEND;
				end
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/vwna_datapath.sv =====
`timescale 1ns / 1ps

module vwna_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vwna_pkg::ctl_cmd_t                  cmd,
	output vwna_pkg::ctl_sts_t                  sts,
	input  logic                                in_cmd,
	input  logic signed [vwna_pkg::POS_W-1:0]   coord_x,
	input  logic signed [vwna_pkg::POS_W-1:0]   coord_y,
	input  logic signed [vwna_pkg::POS_W-1:0]   coord_z,
	input  logic signed [vwna_pkg::NORM_W-1:0]  norm_x,
	input  logic signed [vwna_pkg::NORM_W-1:0]  norm_y,
	input  logic signed [vwna_pkg::NORM_W-1:0]  norm_z,
	input  logic [vwna_pkg::FLOOR_W-1:0]        search_floor,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [vwna_pkg::VIDX_W-1:0]         vertex_index,
	output logic                                is_new,
	output logic                                table_full,
	output logic signed [vwna_pkg::SUM_W-1:0]   sum_x,
	output logic signed [vwna_pkg::SUM_W-1:0]   sum_y,
	output logic signed [vwna_pkg::SUM_W-1:0]   sum_z
);

	localparam int IW = vwna_pkg::IDX_W;
	localparam int CW = vwna_pkg::CNT_W;
	localparam int SW = vwna_pkg::SUM_W;
	localparam int NW = vwna_pkg::NORM_W;
	localparam int EW = vwna_pkg::ENTRY_W;

	logic [vwna_pkg::POS_W-1:0]        cx_q, cy_q, cz_q;
	logic signed [NW-1:0]              nx_q, ny_q, nz_q;
	logic [vwna_pkg::FLOOR_W-1:0]      floor_q;
	logic [CW-1:0]                     fill_q;
	logic [IW-1:0]                     ptr_q;
	logic                              issuing_q;
	logic                              chk_vld_s1;
	logic [IW-1:0]                     chk_addr_s1;

	logic [IW-1:0]                     res_idx_q;
	logic                              res_new_q, res_full_q;
	logic signed [SW-1:0]              res_sx_q, res_sy_q, res_sz_q;
	logic                              out_valid_q;

	logic                              issue, last, is_full;
	logic [EW-1:0]                     pos_rdata, sum_rdata, sum_wdata, pos_wdata;
	logic                              pos_we, sum_we;
	logic [IW-1:0]                     sum_waddr;
	logic signed [SW-1:0]              ax, ay, az, ix, iy, iz;

	assign is_full = (fill_q == CW'(vwna_pkg::TABLE_DEPTH));

	assign sts.scan_need = (in_cmd == vwna_pkg::CMD_WELD)
		&& (vwna_pkg::CMP_W'(fill_q) > vwna_pkg::CMP_W'(search_floor));
	assign sts.match     = chk_vld_s1 && (pos_rdata == {cx_q, cy_q, cz_q});
	assign sts.scan_busy = issuing_q || chk_vld_s1;
	assign sts.out_busy  = out_valid_q && !out_ready;

	assign issue = cmd.scan && issuing_q && !sts.match;
	assign last  = (vwna_pkg::CMP_W'(ptr_q) == vwna_pkg::CMP_W'(floor_q));

	assign ax = vwna_pkg::sat_add(sum_rdata[3*SW-1:2*SW], nx_q);
	assign ay = vwna_pkg::sat_add(sum_rdata[2*SW-1:SW], ny_q);
	assign az = vwna_pkg::sat_add(sum_rdata[SW-1:0], nz_q);

	assign ix = {{(SW - NW){nx_q[NW-1]}}, nx_q};
	assign iy = {{(SW - NW){ny_q[NW-1]}}, ny_q};
	assign iz = {{(SW - NW){nz_q[NW-1]}}, nz_q};

	assign pos_we    = cmd.append && !is_full;
	assign pos_wdata = {cx_q, cy_q, cz_q};
	assign sum_we    = cmd.take_match || pos_we;
	assign sum_waddr = cmd.take_match ? chk_addr_s1 : fill_q[IW-1:0];
	assign sum_wdata = cmd.take_match ? {ax, ay, az} : {ix, iy, iz};

	vwna_ram #(.WIDTH(EW), .DEPTH(vwna_pkg::TABLE_DEPTH)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (fill_q[IW-1:0]),
		.wdata (pos_wdata),
		.re    (issue),
		.raddr (ptr_q),
		.rdata (pos_rdata)
	);

	vwna_ram #(.WIDTH(EW), .DEPTH(vwna_pkg::TABLE_DEPTH)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.re    (issue),
		.raddr (ptr_q),
		.rdata (sum_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cx_q    <= coord_x;
			cy_q    <= coord_y;
			cz_q    <= coord_z;
			nx_q    <= norm_x;
			ny_q    <= norm_y;
			nz_q    <= norm_z;
			floor_q <= search_floor;
			ptr_q   <= IW'(fill_q - CW'(1));
		end else if (issue) begin
			ptr_q <= ptr_q - IW'(1);
		end
		chk_addr_s1 <= ptr_q;
		if (cmd.take_match) begin
			res_idx_q  <= chk_addr_s1;
			res_new_q  <= 1'b0;
			res_full_q <= 1'b0;
			res_sx_q   <= ax;
			res_sy_q   <= ay;
			res_sz_q   <= az;
		end else if (cmd.append) begin
			res_idx_q  <= is_full ? '0 : fill_q[IW-1:0];
			res_new_q  <= !is_full;
			res_full_q <= is_full;
			res_sx_q   <= is_full ? '0 : ix;
			res_sy_q   <= is_full ? '0 : iy;
			res_sz_q   <= is_full ? '0 : iz;
		end
		if (cmd.load_out) begin
			vertex_index <= vwna_pkg::VIDX_W'(res_idx_q);
			is_new       <= res_new_q;
			table_full   <= res_full_q;
			sum_x        <= res_sx_q;
			sum_y        <= res_sy_q;
			sum_z        <= res_sz_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			issuing_q   <= 1'b0;
			chk_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			chk_vld_s1 <= issue;
			if (cmd.accept) begin
				issuing_q <= sts.scan_need;
			end else if (cmd.take_match) begin
				issuing_q <= 1'b0;
			end else if (issue && last) begin
				issuing_q <= 1'b0;
			end
			if (pos_we) begin
				fill_q <= fill_q + CW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(vwna_pkg::TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_match_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		sts.match |-> (CW'(chk_addr_s1) < fill_q))
		else $error("match on an entry never written");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		pos_we |=> (fill_q == $past(fill_q) + CW'(1)))
		else $error("append did not advance fill count");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && !out_ready))
		else $error("result overwrote a waiting item");

endmodule

// ===== design/vertex_weld_normal_accumulate.sv =====
`timescale 1ns / 1ps

// Vertex weld store with normal accumulation.
// Input channel (in_valid/in_ready): one vertex per item, with cmd, position,
// face normal and search floor. Output channel (out_valid/out_ready): one
// result item per input item, in order.
// Weld items scan the stored entries from the newest down to the floor, one
// entry per cycle through the position memory read port; a match updates
// that entry's normal sum, otherwise the vertex is appended unless the table is full.
// A faceted item, or one whose floor is at or above the fill count, skips
// the scan; a scan ends at the first matching entry or after reading all
// entries down to the floor (up to 1024 entries).
// The next item is taken in the cycle after the result is loaded into the
// output register.
// Reset empties the table (fill count zero) and drops any waiting result;
// the memories are not cleared.
// A stalled receiver holds the result in the output register; one further
// item is then accepted and processed, and its result waits until the
// output register is free.
module vertex_weld_normal_accumulate (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                cmd,
	input  logic signed [vwna_pkg::POS_W-1:0]   coord_x,
	input  logic signed [vwna_pkg::POS_W-1:0]   coord_y,
	input  logic signed [vwna_pkg::POS_W-1:0]   coord_z,
	input  logic signed [vwna_pkg::NORM_W-1:0]  norm_x,
	input  logic signed [vwna_pkg::NORM_W-1:0]  norm_y,
	input  logic signed [vwna_pkg::NORM_W-1:0]  norm_z,
	input  logic [vwna_pkg::FLOOR_W-1:0]        search_floor,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [vwna_pkg::VIDX_W-1:0]         vertex_index,
	output logic                                is_new,
	output logic                                table_full,
	output logic signed [vwna_pkg::SUM_W-1:0]   sum_x,
	output logic signed [vwna_pkg::SUM_W-1:0]   sum_y,
	output logic signed [vwna_pkg::SUM_W-1:0]   sum_z
);

	vwna_pkg::ctl_cmd_t ctl_cmd;
	vwna_pkg::ctl_sts_t ctl_sts;

	vwna_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (ctl_sts),
		.cmd      (ctl_cmd)
	);

	vwna_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctl_cmd),
		.sts          (ctl_sts),
		.in_cmd       (cmd),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.coord_z      (coord_z),
		.norm_x       (norm_x),
		.norm_y       (norm_y),
		.norm_z       (norm_z),
		.search_floor (search_floor),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.vertex_index (vertex_index),
		.is_new       (is_new),
		.table_full   (table_full),
		.sum_x        (sum_x),
		.sum_y        (sum_y),
		.sum_z        (sum_z)
	);

endmodule

// ===== tb/vertex_weld_normal_accumulate_test.sv =====
`timescale 1ns / 1ps

module vertex_weld_normal_accumulate_test;

	typedef struct packed {
		logic                               cmd;
		logic signed [vwna_pkg::POS_W-1:0]  px, py, pz;
		logic signed [vwna_pkg::NORM_W-1:0] nx, ny, nz;
		logic [vwna_pkg::FLOOR_W-1:0]       lo;
	} vertex_t;

	typedef struct packed {
		logic [vwna_pkg::VIDX_W-1:0]       idx;
		logic                              is_new;
		logic                              full;
		logic signed [vwna_pkg::SUM_W-1:0] sx, sy, sz;
	} weld_result_t;

	typedef struct packed {
		vertex_t      v;
		logic         known;
		weld_result_t r;
	} stim_row_t;

	localparam logic [vwna_pkg::POS_W-1:0]  P_MAX = 32'h7fffffff;
	localparam logic [vwna_pkg::POS_W-1:0]  P_MIN = 32'h80000000;
	localparam logic [vwna_pkg::NORM_W-1:0] N_MAX = 16'h7fff;
	localparam logic [vwna_pkg::NORM_W-1:0] N_MIN = 16'h8000;
	localparam logic signed [vwna_pkg::SUM_W-1:0] S_MAX = 32'sh7fffffff;
	localparam logic signed [vwna_pkg::SUM_W-1:0] S_MIN = 32'sh80000000;

	localparam int N_ROWS = 23;
	localparam stim_row_t STIM_ROWS [N_ROWS] = '{
		'{'{vwna_pkg::CMD_WELD, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 11'd0},
			1'b1, '{10'd0, 1'b1, 1'b0, 32'sd0, 32'sd0, 32'sd0}},
		'{'{vwna_pkg::CMD_FACETED, P_MAX, P_MIN, 32'hffffffff, N_MAX, N_MIN, 16'hffff,
			11'd2047}, 1'b1, '{10'd1, 1'b1, 1'b0, 32'sd32767, -32'sd32768, -32'sd1}},
		'{'{vwna_pkg::CMD_WELD, P_MAX, P_MIN, 32'hffffffff, N_MAX, N_MIN, 16'h0001,
			11'd0}, 1'b1, '{10'd1, 1'b0, 1'b0, 32'sd65534, -32'sd65536, 32'sd0}},
		'{'{vwna_pkg::CMD_FACETED, P_MAX, P_MIN, 32'hffffffff, 16'h1, 16'h1, 16'h1,
			11'd0}, 1'b1, '{10'd2, 1'b1, 1'b0, 32'sd1, 32'sd1, 32'sd1}},
		'{'{vwna_pkg::CMD_WELD, P_MAX, P_MIN, 32'hffffffff, 16'h5, 16'hfffb, 16'h0, 11'd0},
			1'b0, '0},
		'{'{vwna_pkg::CMD_WELD, P_MAX, P_MIN, 32'hffffffff, 16'h1, 16'h1, 16'h1, 11'd2},
			1'b0, '0},
		'{'{vwna_pkg::CMD_WELD, P_MAX, P_MIN, 32'hffffffff, 16'h1, 16'h1, 16'h1, 11'd3},
			1'b0, '0},
		'{'{vwna_pkg::CMD_WELD, P_MAX, P_MIN, 32'hffffffff, 16'h2, 16'h2, 16'h2, 11'd1024},
			1'b0, '0},
		'{'{vwna_pkg::CMD_WELD, P_MAX, P_MIN, 32'hfffffffe, 16'h3, 16'h3, 16'h3, 11'd0},
			1'b0, '0},
		'{'{vwna_pkg::CMD_WELD, P_MAX, 32'h80000001, 32'hffffffff, 16'h4, 16'h4, 16'h4,
			11'd0}, 1'b0, '0},
		'{'{vwna_pkg::CMD_WELD, 32'h7ffffffe, P_MIN, 32'hffffffff, 16'h5, 16'h5, 16'h5,
			11'd0}, 1'b0, '0},
		'{'{vwna_pkg::CMD_WELD, 32'h0, 32'h0, 32'h0, N_MIN, N_MIN, N_MIN, 11'd0},
			1'b0, '0},
		'{'{vwna_pkg::CMD_WELD, 32'h0, 32'h0, 32'h0, N_MAX, N_MAX, N_MAX, 11'd1},
			1'b0, '0},
		'{'{vwna_pkg::CMD_WELD, 32'h0, 32'h0, 32'h0, N_MAX, N_MIN, 16'h0, 11'd0},
			1'b0, '0},
		'{'{vwna_pkg::CMD_FACETED, P_MIN, P_MAX, 32'h0, N_MIN, N_MAX, 16'h0, 11'd0},
			1'b0, '0},
		'{'{vwna_pkg::CMD_WELD, P_MIN, P_MAX, 32'h0, N_MIN, N_MIN, N_MIN, 11'd9},
			1'b0, '0},
		'{'{vwna_pkg::CMD_WELD, 32'h00010000, 32'hffff0000, 32'h00008000, 16'h4000,
			16'hc000, 16'h2000, 11'd10}, 1'b0, '0},
		'{'{vwna_pkg::CMD_WELD, 32'h00010000, 32'hffff0000, 32'h00008000, 16'h4000,
			16'hc000, 16'h2000, 11'd2047}, 1'b0, '0},
		'{'{vwna_pkg::CMD_WELD, 32'h00010000, 32'hffff0000, 32'h00008000, 16'h4000,
			16'hc000, 16'h2000, 11'd0}, 1'b0, '0},
		'{'{vwna_pkg::CMD_FACETED, 32'h0, 32'h0, 32'h0, 16'h1, 16'h2, 16'h3, 11'd0},
			1'b0, '0},
		'{'{vwna_pkg::CMD_WELD, 32'h55555555, 32'haaaaaaaa, 32'h33333333, 16'h5555,
			16'haaaa, 16'h3333, 11'h555}, 1'b0, '0},
		'{'{vwna_pkg::CMD_WELD, 32'haaaaaaaa, 32'h55555555, 32'hcccccccc, 16'haaaa,
			16'h5555, 16'hcccc, 11'h2aa}, 1'b0, '0},
		'{'{vwna_pkg::CMD_WELD, 32'h55555555, 32'haaaaaaaa, 32'h33333333, 16'h5555,
			16'haaaa, 16'h3333, 11'd0}, 1'b0, '0}
	};

	localparam int SEND_PCT [4] = '{0, 62, 0, 38};
	localparam int RECV_PCT [4] = '{0, 0, 62, 38};
	localparam int RANDOM_PER_PHASE = 139;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic                               cmd = vwna_pkg::CMD_WELD;
	logic signed [vwna_pkg::POS_W-1:0]  coord_x = '0;
	logic signed [vwna_pkg::POS_W-1:0]  coord_y = '0;
	logic signed [vwna_pkg::POS_W-1:0]  coord_z = '0;
	logic signed [vwna_pkg::NORM_W-1:0] norm_x = '0;
	logic signed [vwna_pkg::NORM_W-1:0] norm_y = '0;
	logic signed [vwna_pkg::NORM_W-1:0] norm_z = '0;
	logic [vwna_pkg::FLOOR_W-1:0]       search_floor = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic [vwna_pkg::VIDX_W-1:0]        vertex_index;
	logic                               is_new;
	logic                               table_full;
	logic signed [vwna_pkg::SUM_W-1:0]  sum_x;
	logic signed [vwna_pkg::SUM_W-1:0]  sum_y;
	logic signed [vwna_pkg::SUM_W-1:0]  sum_z;

	logic signed [vwna_pkg::POS_W-1:0] mdl_px [vwna_pkg::TABLE_DEPTH];
	logic signed [vwna_pkg::POS_W-1:0] mdl_py [vwna_pkg::TABLE_DEPTH];
	logic signed [vwna_pkg::POS_W-1:0] mdl_pz [vwna_pkg::TABLE_DEPTH];
	logic signed [vwna_pkg::SUM_W-1:0] mdl_sx [vwna_pkg::TABLE_DEPTH];
	logic signed [vwna_pkg::SUM_W-1:0] mdl_sy [vwna_pkg::TABLE_DEPTH];
	logic signed [vwna_pkg::SUM_W-1:0] mdl_sz [vwna_pkg::TABLE_DEPTH];
	int                                mdl_fill = 0;

	weld_result_t expected_q [$];
	int unsigned  n_mismatch = 0;
	int unsigned  n_checked = 0;
	int unsigned  n_welded = 0;
	int unsigned  n_appended = 0;
	int unsigned  n_refused = 0;
	int unsigned  n_railed = 0;
	int           send_idle = 0;
	int           recv_stall = 0;

	vertex_weld_normal_accumulate uut (
		.clk, .arst_n,
		.in_valid, .in_ready,
		.cmd, .coord_x, .coord_y, .coord_z, .norm_x, .norm_y, .norm_z, .search_floor,
		.out_valid, .out_ready,
		.vertex_index, .is_new, .table_full, .sum_x, .sum_y, .sum_z
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [vwna_pkg::SUM_W-1:0] clip_add(
			logic signed [vwna_pkg::SUM_W-1:0] s, logic signed [vwna_pkg::NORM_W-1:0] d);
		longint t;
		t = longint'(s) + longint'(d);
		if (t > longint'(S_MAX))
			return S_MAX;
		if (t < longint'(S_MIN))
			return S_MIN;
		return t[vwna_pkg::SUM_W-1:0];
	endfunction

	task automatic weld_predict(input vertex_t v, output weld_result_t r);
		int e;
		int hit;
		hit = -1;
		r = '0;
		if (v.cmd == vwna_pkg::CMD_WELD) begin
			for (e = mdl_fill - 1; e >= 0 && e >= int'(v.lo) && hit < 0; e--) begin
				if (mdl_px[e] == v.px && mdl_py[e] == v.py && mdl_pz[e] == v.pz)
					hit = e;
			end
		end
		if (hit >= 0) begin
			mdl_sx[hit] = clip_add(mdl_sx[hit], v.nx);
			mdl_sy[hit] = clip_add(mdl_sy[hit], v.ny);
			mdl_sz[hit] = clip_add(mdl_sz[hit], v.nz);
			r.idx = hit[vwna_pkg::VIDX_W-1:0];
			r.sx = mdl_sx[hit];
			r.sy = mdl_sy[hit];
			r.sz = mdl_sz[hit];
			n_welded++;
			if (r.sx inside {S_MAX, S_MIN} || r.sy inside {S_MAX, S_MIN}
					|| r.sz inside {S_MAX, S_MIN})
				n_railed++;
		end else if (mdl_fill >= vwna_pkg::TABLE_DEPTH) begin
			r.full = 1'b1;
			n_refused++;
		end else begin
			mdl_px[mdl_fill] = v.px;
			mdl_py[mdl_fill] = v.py;
			mdl_pz[mdl_fill] = v.pz;
			mdl_sx[mdl_fill] = v.nx;
			mdl_sy[mdl_fill] = v.ny;
			mdl_sz[mdl_fill] = v.nz;
			r.idx = mdl_fill[vwna_pkg::VIDX_W-1:0];
			r.is_new = 1'b1;
			r.sx = mdl_sx[mdl_fill];
			r.sy = mdl_sy[mdl_fill];
			r.sz = mdl_sz[mdl_fill];
			mdl_fill++;
			n_appended++;
		end
	endtask

	function automatic logic signed [vwna_pkg::POS_W-1:0] draw_coord();
		case ($urandom_range(0, 9))
			0: return P_MAX;
			1: return P_MIN;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [vwna_pkg::NORM_W-1:0] draw_norm();
		case ($urandom_range(0, 9))
			0: return N_MAX;
			1: return N_MIN;
			2: return '0;
			3: return '1;
			default: return vwna_pkg::NORM_W'($urandom);
		endcase
	endfunction

	function automatic vertex_t random_vertex();
		vertex_t v;
		int      pick;
		int      e;
		int      b;
		v.cmd = ($urandom_range(0, 99) < 20) ? vwna_pkg::CMD_FACETED : vwna_pkg::CMD_WELD;
		pick = $urandom_range(0, 99);
		if (mdl_fill > 0 && pick < 65) begin
			// favour recent entries so that short scans hit as well
			if ($urandom_range(0, 1))
				e = mdl_fill - 1 - int'($urandom_range(0, (mdl_fill > 8) ? 7 : mdl_fill - 1));
			else
				e = $urandom_range(0, mdl_fill - 1);
			v.px = mdl_px[e];
			v.py = mdl_py[e];
			v.pz = mdl_pz[e];
			if (pick >= 55) begin
				b = $urandom_range(0, vwna_pkg::POS_W - 1);
				case ($urandom_range(0, 2))
					0: v.px[b] = ~v.px[b];
					1: v.py[b] = ~v.py[b];
					default: v.pz[b] = ~v.pz[b];
				endcase
			end
		end else begin
			v.px = draw_coord();
			v.py = draw_coord();
			v.pz = draw_coord();
		end
		v.nx = draw_norm();
		v.ny = draw_norm();
		v.nz = draw_norm();
		pick = $urandom_range(0, 99);
		if (pick < 55)
			v.lo = '0;
		else if (pick < 80)
			v.lo = vwna_pkg::FLOOR_W'($urandom_range(0, mdl_fill));
		else if (pick < 90)
			v.lo = vwna_pkg::FLOOR_W'(mdl_fill);
		else
			v.lo = vwna_pkg::FLOOR_W'($urandom_range(0, 2047));
		return v;
	endfunction

	task automatic push_vertex(input vertex_t v, input logic known,
			input weld_result_t typed_res);
		weld_result_t pred;
		if ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
		end
		in_valid <= 1'b1;
		cmd <= v.cmd;
		coord_x <= v.px;
		coord_y <= v.py;
		coord_z <= v.pz;
		norm_x <= v.nx;
		norm_y <= v.ny;
		norm_z <= v.nz;
		search_floor <= v.lo;
		do @(posedge clk); while (!in_ready);
		weld_predict(v, pred);
		expected_q.push_back(known ? typed_res : pred);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at result %0d: %s is %0d, expected %0d", n_checked, what, got, want);
		n_mismatch++;
	endtask

	task automatic take_result();
		weld_result_t want;
		if (expected_q.size() == 0) begin
			report_mismatch("unrequested result, vertex_index", vertex_index, -1);
			return;
		end
		want = expected_q.pop_front();
		n_checked++;
		if (vertex_index !== want.idx)
			report_mismatch("vertex_index", vertex_index, want.idx);
		if (is_new !== want.is_new)
			report_mismatch("is_new", is_new, want.is_new);
		if (table_full !== want.full)
			report_mismatch("table_full", table_full, want.full);
		if (sum_x !== want.sx)
			report_mismatch("sum_x", sum_x, want.sx);
		if (sum_y !== want.sy)
			report_mismatch("sum_y", sum_y, want.sy);
		if (sum_z !== want.sz)
			report_mismatch("sum_z", sum_z, want.sz);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			take_result();
		out_ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	initial begin
		int i;
		int ph;
		int wait_n;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_ROWS; i++)
			push_vertex(STIM_ROWS[i].v, STIM_ROWS[i].known, STIM_ROWS[i].r);

		for (ph = 0; ph < 4; ph++) begin
			send_idle = SEND_PCT[ph];
			recv_stall = RECV_PCT[ph];
			for (i = 0; i < RANDOM_PER_PHASE; i++)
				push_vertex(random_vertex(), 1'b0, '0);
		end

		in_valid <= 1'b0;
		for (wait_n = 0; expected_q.size() != 0 && wait_n < 200000; wait_n++)
			@(posedge clk);
		repeat (1100) @(posedge clk);
		if (expected_q.size() != 0)
			report_mismatch("results outstanding", 0, expected_q.size());

		$display("%0d results compared: %0d welded, %0d appended, %0d refused on a full table",
			n_checked, n_welded, n_appended, n_refused);
		$display("%0d welds left a sum on a rail; random items ran under four idle mixes",
			n_railed);
		if (n_mismatch == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#(100_000_000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
